### sv/word_run_scanner_unit_defines.svh
// Assertion macros for the word run scanner.
// Used by the scanner core and the result queue; no other dependencies.
`ifndef WORD_RUN_SCANNER_UNIT_DEFINES_SVH
`define WORD_RUN_SCANNER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Plain property, checked at every clock edge outside reset.
`define WRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("word run scanner: assertion failed");
// Antecedent implies consequent in the same cycle.
`define WRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("word run scanner: implication failed");
`else
`define WRS_ASSERT(lbl, clk, rstn, prop)
`define WRS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/wrs_pkg.sv
// Shared types, constants and helpers of the word run scanner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned CNT_W        = 31;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int unsigned ADDR_BITS_DEF = 32;
  localparam int unsigned WORD_BYTES   = 4;
  localparam int unsigned ALIGN_LOW    = WORD_BYTES - 1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_VALUE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORDS  = 2'd2;

  localparam logic [WORD_W-1:0] MATCH_VALUE_RST  = '0;
  localparam logic [WORD_W-1:0] BASE_ADDRESS_RST = '0;
  localparam logic [WORD_W-1:0] MAX_RECORDS_RST  = '1;

  // Result kinds
  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Result queue
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);

  typedef struct packed {
    logic [WORD_W-1:0] mem_word;
    logic              has_word;
    logic              last_word;
  } in_item_t;

  typedef struct packed {
    logic              record_kind;
    logic [WORD_W-1:0] start_address;
    logic [CNT_W-1:0]  run_words;
    logic [CNT_W-1:0]  total_words;
    logic [CNT_W-1:0]  run_count;
    logic [CNT_W-1:0]  longest_run;
    logic              final_result;
  } res_item_t;

  // Results of one item, oldest first; valid[1] only with valid[0].
  typedef struct packed {
    logic [1:0] valid;
    res_item_t  first;
    res_item_t  second;
  } res_push_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

### sv/wrs_core.sv
// Scan state and per-item result generation of the word run scanner.
// Depends on wrs_pkg and word_run_scanner_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "word_run_scanner_unit_defines.svh"

module wrs_core #(
  parameter int unsigned ADDR_BITS = wrs_pkg::ADDR_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  wrs_pkg::in_item_t          item_i,
  input  logic [wrs_pkg::WORD_W-1:0] match_value_i,
  input  logic [wrs_pkg::WORD_W-1:0] base_address_i,
  input  logic [wrs_pkg::WORD_W-1:0] max_records_i,
  output wrs_pkg::res_push_t         push_o
);

  localparam int unsigned CW        = wrs_pkg::CNT_W;
  localparam int unsigned SUM_W     = wrs_pkg::WORD_W + 1;
  localparam int unsigned EXT_W     = (ADDR_BITS > SUM_W) ? ADDR_BITS : SUM_W;
  localparam int unsigned OUT_EXT_W = (ADDR_BITS > wrs_pkg::WORD_W) ? ADDR_BITS
                                                                   : wrs_pkg::WORD_W;

  logic                       scan_open_q, scan_open_d;
  logic [ADDR_BITS-1:0]       word_addr_q, word_addr_d;
  logic                       in_run_q, in_run_d;
  logic [ADDR_BITS-1:0]       run_start_q, run_start_d;
  logic [CW-1:0]              run_len_q, run_len_d;
  logic [CW-1:0]              total_q, total_d;
  logic [CW-1:0]              tally_q, tally_d;
  logic [CW-1:0]              longest_q, longest_d;
  logic [wrs_pkg::WORD_W-1:0] sent_q, sent_d;

  logic [SUM_W-1:0]     base_sum;
  logic [EXT_W-1:0]     base_ext;
  logic [ADDR_BITS-1:0] first_addr, addr_cur, start1;
  logic [OUT_EXT_W-1:0] start_ext;
  logic [CW-1:0]        len1, total1, tally_c, longest_c;
  logic                 is_match, in_run1, close_a, close_b, closing, emit_rec, scan_end;
  wrs_pkg::res_item_t   rec, summ;

  // Round the base up to a word boundary, then fit it to the address width.
  assign base_sum   = {1'b0, base_address_i} + SUM_W'(wrs_pkg::ALIGN_LOW);
  assign base_ext   = EXT_W'({base_sum[SUM_W-1:2], 2'b00});
  assign first_addr = base_ext[ADDR_BITS-1:0];
  assign addr_cur   = scan_open_q ? word_addr_q : first_addr;

  always_comb begin
    is_match = item_i.has_word && (item_i.mem_word == match_value_i);
    scan_end = !item_i.has_word || item_i.last_word;

    // Extend or start the run on a matching word.
    in_run1 = in_run_q;
    start1  = run_start_q;
    len1    = run_len_q;
    total1  = total_q;
    if (is_match) begin
      in_run1 = 1'b1;
      start1  = in_run_q ? run_start_q : addr_cur;
      len1    = wrs_pkg::sat_inc(in_run_q ? run_len_q : '0);
      total1  = wrs_pkg::sat_inc(total_q);
    end

    // A mismatch or the end of the scan closes the run; both can hold at once.
    close_a  = item_i.has_word && !is_match && in_run_q;
    close_b  = scan_end && in_run1;
    closing  = close_a || close_b;
    emit_rec = closing && (sent_q < max_records_i);

    tally_c   = closing ? wrs_pkg::sat_inc(tally_q) : tally_q;
    longest_c = (closing && (len1 > longest_q)) ? len1 : longest_q;

    start_ext = OUT_EXT_W'(start1);

    rec               = '0;
    rec.record_kind   = wrs_pkg::KIND_RUN;
    rec.start_address = start_ext[wrs_pkg::WORD_W-1:0];
    rec.run_words     = len1;
    rec.final_result  = !scan_end;

    summ              = '0;
    summ.record_kind  = wrs_pkg::KIND_SUMMARY;
    summ.total_words  = total1;
    summ.run_count    = tally_c;
    summ.longest_run  = longest_c;
    summ.final_result = 1'b1;

    push_o.first  = emit_rec ? rec : summ;
    push_o.second = summ;
    push_o.valid  = '0;
    if (step_i) begin
      push_o.valid[0] = emit_rec || scan_end;
      push_o.valid[1] = emit_rec && scan_end;
    end

    // Next state
    scan_open_d = scan_open_q;
    word_addr_d = word_addr_q;
    in_run_d    = in_run_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    total_d     = total_q;
    tally_d     = tally_q;
    longest_d   = longest_q;
    sent_d      = sent_q;
    if (step_i) begin
      if (scan_end) begin
        scan_open_d = 1'b0;
        word_addr_d = '0;
        in_run_d    = 1'b0;
        run_start_d = '0;
        run_len_d   = '0;
        total_d     = '0;
        tally_d     = '0;
        longest_d   = '0;
        sent_d      = '0;
      end else begin
        scan_open_d = 1'b1;
        word_addr_d = addr_cur + ADDR_BITS'(wrs_pkg::WORD_BYTES);
        in_run_d    = closing ? 1'b0 : in_run1;
        run_start_d = start1;
        run_len_d   = closing ? '0 : len1;
        total_d     = total1;
        tally_d     = tally_c;
        longest_d   = longest_c;
        sent_d      = emit_rec ? sent_q + wrs_pkg::WORD_W'(1) : sent_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_open_q <= 1'b0;
      word_addr_q <= '0;
      in_run_q    <= 1'b0;
      run_start_q <= '0;
      run_len_q   <= '0;
      total_q     <= '0;
      tally_q     <= '0;
      longest_q   <= '0;
      sent_q      <= '0;
    end else begin
      scan_open_q <= scan_open_d;
      word_addr_q <= word_addr_d;
      in_run_q    <= in_run_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      total_q     <= total_d;
      tally_q     <= tally_d;
      longest_q   <= longest_d;
      sent_q      <= sent_d;
    end
  end

  `WRS_ASSERT_IMPL(a_run_in_scan, clk_i, rst_ni, in_run_q, scan_open_q)
  `WRS_ASSERT(a_len_tracks_run, clk_i, rst_ni, in_run_q == (run_len_q != '0))
  `WRS_ASSERT(a_summary_clears, clk_i, rst_ni, (step_i && scan_end) |=> (!scan_open_q && (sent_q == '0) && (total_q == '0)))

endmodule

`default_nettype wire

### sv/wrs_res_fifo.sv
// Small result queue of the word run scanner: two writes, one read a cycle.
// Depends on wrs_pkg and word_run_scanner_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "word_run_scanner_unit_defines.svh"

module wrs_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wrs_pkg::res_push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wrs_pkg::res_item_t out_item_o
);

  localparam int unsigned DEPTH = wrs_pkg::RES_DEPTH;
  localparam int unsigned PW    = wrs_pkg::RES_PTR_W;
  localparam int unsigned NW    = PW + 1;

  wrs_pkg::res_item_t entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [NW-1:0] cnt_q, cnt_d, push_n;
  logic          pop;

  assign push_n      = NW'(push_i.valid[0]) + NW'(push_i.valid[1]);
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = entry_q[rd_ptr_q];
  // Room for the worst case of two results from the next item.
  assign room_o      = (cnt_q <= NW'(DEPTH - 2));
  assign wr_ptr_nx   = wr_ptr_q + PW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_n[PW-1:0];
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + push_n - NW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid[0]) begin
      entry_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.valid[1]) begin
      entry_q[wr_ptr_nx] <= push_i.second;
    end
  end

  `WRS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= NW'(DEPTH))
  `WRS_ASSERT_IMPL(a_pair_order, clk_i, rst_ni, push_i.valid[1], push_i.valid[0])
  `WRS_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i.valid[0], room_o)

endmodule

`default_nettype wire

### sv/word_run_scanner_unit.sv
// Top level of the word run scanner: configuration, input register, core, queue.
// Depends on wrs_pkg, wrs_core and wrs_res_fifo.
//
//   channel   signals                              direction
//   -------   ----------------------------------   ---------
//   input     in_valid_i / in_ready_o / in_item_i  in
//   output    out_valid_o / out_ready_i / out_item_o out
//   config    cfg_we_i / cfg_idx_i / cfg_wdata_i   in, write only
//
// An item enters the input register; when the queue has room, the core
// compares it, updates the run counters and writes zero, one or two results
// into a four-entry queue. One item a cycle is sustained while results drain
// one a cycle; both results of an item go in together, then leave singly.
// Output valid is set once a result sits in the queue.
// Input ready depends only on registered state: it drops when the input
// register is full and the queue cannot take two more results.
// Reset clears all scan state and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module word_run_scanner_unit #(
  parameter int unsigned ADDR_BITS = wrs_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wrs_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wrs_pkg::res_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [wrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wrs_pkg::WORD_W-1:0]    cfg_wdata_i
);

  logic [wrs_pkg::WORD_W-1:0] match_value_q, base_address_q, max_records_q;
  logic                       in_vld_q, in_vld_d;
  wrs_pkg::in_item_t          in_item_q;
  logic                       room, step, in_take;
  wrs_pkg::res_push_t         push;

  // Configuration registers; an unknown index writes nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_value_q  <= wrs_pkg::MATCH_VALUE_RST;
      base_address_q <= wrs_pkg::BASE_ADDRESS_RST;
      max_records_q  <= wrs_pkg::MAX_RECORDS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wrs_pkg::REG_MATCH_VALUE:  match_value_q  <= cfg_wdata_i;
        wrs_pkg::REG_BASE_ADDRESS: base_address_q <= cfg_wdata_i;
        wrs_pkg::REG_MAX_RECORDS:  max_records_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the held item when the queue has room for its results; take a
  // new item whenever the input register frees up in this cycle.
  assign step       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || room;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Hold the payload until the core has used it.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
  end

  wrs_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (in_item_q),
    .match_value_i  (match_value_q),
    .base_address_i (base_address_q),
    .max_records_i  (max_records_q),
    .push_o         (push)
  );

  wrs_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for word_run_scanner_unit: scans, register writes and result checks.
// Depends on wrs_pkg and the RTL of the scanner; nothing else.

module tb;

  // Cycles with no item moving on either channel before the run is given up.
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned RANDOM_ITEMS  = 850;
  // Long receiver hold-off: starts once this many results have been taken.
  localparam int unsigned HOLD_AFTER    = 150;
  localparam int unsigned HOLD_CYCLES   = 400;
  // Extra settling after the last expected result, for trailing items with no result.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PRINT_LIMIT   = 50;

  // Predicts run records and summaries, and holds them until the block sends them.
  class run_scoreboard;
    logic [wrs_pkg::WORD_W-1:0] match_value;
    logic [wrs_pkg::WORD_W-1:0] base_address;
    logic [wrs_pkg::WORD_W-1:0] max_records;
    logic                       scan_open;
    logic                       in_run;
    logic [wrs_pkg::WORD_W-1:0] word_address;
    logic [wrs_pkg::WORD_W-1:0] run_start;
    logic [wrs_pkg::WORD_W-1:0] records_sent;
    logic [wrs_pkg::CNT_W-1:0]  run_length;
    logic [wrs_pkg::CNT_W-1:0]  match_total;
    logic [wrs_pkg::CNT_W-1:0]  run_tally;
    logic [wrs_pkg::CNT_W-1:0]  longest_seen;
    wrs_pkg::res_item_t         expected_q[$];
    int unsigned                errors;

    function new();
      match_value  = wrs_pkg::MATCH_VALUE_RST;
      base_address = wrs_pkg::BASE_ADDRESS_RST;
      max_records  = wrs_pkg::MAX_RECORDS_RST;
      errors       = 0;
      clear_scan();
    endfunction

    function void set_reg(logic [wrs_pkg::CFG_IDX_W-1:0] idx,
                          logic [wrs_pkg::WORD_W-1:0] value);
      case (idx)
        wrs_pkg::REG_MATCH_VALUE:  match_value  = value;
        wrs_pkg::REG_BASE_ADDRESS: base_address = value;
        wrs_pkg::REG_MAX_RECORDS:  max_records  = value;
        default: ;
      endcase
    endfunction

    function void clear_scan();
      scan_open    = 1'b0;
      in_run       = 1'b0;
      word_address = '0;
      run_start    = '0;
      records_sent = '0;
      run_length   = '0;
      match_total  = '0;
      run_tally    = '0;
      longest_seen = '0;
    endfunction

    // Counters stick at their top value.
    function logic [wrs_pkg::CNT_W-1:0] bump(logic [wrs_pkg::CNT_W-1:0] v);
      return (v == wrs_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    function void push_result(logic kind, logic [wrs_pkg::WORD_W-1:0] addr,
                              logic [wrs_pkg::CNT_W-1:0] run,
                              logic [wrs_pkg::CNT_W-1:0] total,
                              logic [wrs_pkg::CNT_W-1:0] count,
                              logic [wrs_pkg::CNT_W-1:0] longest);
      wrs_pkg::res_item_t r;
      r.record_kind   = kind;
      r.start_address = addr;
      r.run_words     = run;
      r.total_words   = total;
      r.run_count     = count;
      r.longest_run   = longest;
      r.final_result  = 1'b0;
      expected_q.push_back(r);
    endfunction

    // Close an open run; a record goes out only while under the record limit.
    function void end_run();
      if (!in_run) return;
      run_tally = bump(run_tally);
      if (run_length > longest_seen) longest_seen = run_length;
      if (records_sent < max_records) begin
        push_result(wrs_pkg::KIND_RUN, run_start, run_length, '0, '0, '0);
        records_sent = records_sent + 1'b1;
      end
      in_run     = 1'b0;
      run_length = '0;
    endfunction

    function void note_item(wrs_pkg::in_item_t it);
      int unsigned        queued;
      wrs_pkg::res_item_t tail;
      queued = expected_q.size();
      if (it.has_word) begin
        if (!scan_open) begin
          scan_open    = 1'b1;
          word_address = (base_address + wrs_pkg::ALIGN_LOW)
                         & ~wrs_pkg::WORD_W'(wrs_pkg::ALIGN_LOW);
        end
        if (it.mem_word == match_value) begin
          if (!in_run) begin
            in_run     = 1'b1;
            run_start  = word_address;
            run_length = '0;
          end
          run_length  = bump(run_length);
          match_total = bump(match_total);
        end else begin
          end_run();
        end
        word_address = word_address + wrs_pkg::WORD_BYTES;
      end
      // A wordless item closes the scan whatever last_word says.
      if (!it.has_word || it.last_word) begin
        end_run();
        push_result(wrs_pkg::KIND_SUMMARY, '0, '0, match_total, run_tally, longest_seen);
        clear_scan();
      end
      if (expected_q.size() > queued) begin
        tail = expected_q.pop_back();
        tail.final_result = 1'b1;
        expected_q.push_back(tail);
      end
    endfunction

    task report(string what, logic [wrs_pkg::WORD_W-1:0] got,
                logic [wrs_pkg::WORD_W-1:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("[%0t] mismatch, %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    endtask

    task check_result(wrs_pkg::res_item_t got);
      wrs_pkg::res_item_t want;
      if (expected_q.size() == 0) begin
        report("result with nothing expected, start_address", got.start_address, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.record_kind !== want.record_kind)
        report("record_kind", got.record_kind, want.record_kind);
      if (got.start_address !== want.start_address)
        report("start_address", got.start_address, want.start_address);
      if (got.run_words !== want.run_words)
        report("run_words", got.run_words, want.run_words);
      if (got.total_words !== want.total_words)
        report("total_words", got.total_words, want.total_words);
      if (got.run_count !== want.run_count)
        report("run_count", got.run_count, want.run_count);
      if (got.longest_run !== want.longest_run)
        report("longest_run", got.longest_run, want.longest_run);
      if (got.final_result !== want.final_result)
        report("final_result", got.final_result, want.final_result);
    endtask

    task flush_leftovers();
      wrs_pkg::res_item_t want;
      while (expected_q.size() != 0) begin
        want = expected_q.pop_front();
        report("result never sent, run_words", '0, want.run_words);
      end
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  wrs_pkg::in_item_t             in_item;
  logic                          out_valid;
  logic                          out_ready;
  wrs_pkg::res_item_t            out_item;
  logic                          cfg_we;
  logic [wrs_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [wrs_pkg::WORD_W-1:0]    cfg_wdata;

  run_scoreboard board;
  int unsigned   burst_left;
  int unsigned   items_sent;
  int unsigned   results_taken;

  word_run_scanner_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Offer one item and hold it until accepted. The sender works in bursts: when a
  // burst runs out, drop valid for a random gap, possibly none, and pick the next burst length.
  // Valid stays high between items of a burst, so it is never lowered and raised
  // in the same step.
  task automatic send_item(logic [wrs_pkg::WORD_W-1:0] word, logic has, logic last);
    wrs_pkg::in_item_t it;
    int unsigned       gap;
    it.mem_word  = word;
    it.has_word  = has;
    it.last_word = last;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(it);
    items_sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle so
  // that a trailing item with no result has surely left the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; only called while idle.
  task automatic write_config(logic [wrs_pkg::WORD_W-1:0] mv,
                              logic [wrs_pkg::WORD_W-1:0] ba,
                              logic [wrs_pkg::WORD_W-1:0] mr);
    cfg_we    <= 1'b1;
    cfg_idx   <= wrs_pkg::REG_MATCH_VALUE;
    cfg_wdata <= mv;
    @(posedge clk);
    board.set_reg(wrs_pkg::REG_MATCH_VALUE, mv);
    cfg_idx   <= wrs_pkg::REG_BASE_ADDRESS;
    cfg_wdata <= ba;
    @(posedge clk);
    board.set_reg(wrs_pkg::REG_BASE_ADDRESS, ba);
    cfg_idx   <= wrs_pkg::REG_MAX_RECORDS;
    cfg_wdata <= mr;
    @(posedge clk);
    board.set_reg(wrs_pkg::REG_MAX_RECORDS, mr);
    cfg_we    <= 1'b0;
  endtask

  // One whole scan of random content: a random share of words equal to the match value so
  // that runs form, some one bit off it, the rest arbitrary. Close it either with
  // the last-word flag or with a wordless item; no words and a wordless close
  // give an empty range.
  task automatic scan_words(int unsigned count, bit close_empty);
    logic [wrs_pkg::WORD_W-1:0] w;
    int unsigned                density;
    int unsigned                n;
    density = $urandom_range(2, 9);
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < density) w = board.match_value;
      else if ($urandom_range(0, 3) == 0) w = board.match_value ^ (32'd1 << $urandom_range(0, 31));
      else w = $urandom;
      send_item(w, 1'b1, !close_empty && (n == count - 1));
    end
    if (close_empty) send_item($urandom, 1'b0, $urandom_range(0, 1));
  endtask

  // Main sequence: reset, directed scans, then random phases under varied settings.
  initial begin
    logic [wrs_pkg::WORD_W-1:0] mv;
    logic [wrs_pkg::WORD_W-1:0] ba;
    logic [wrs_pkg::WORD_W-1:0] mr;
    int unsigned                phase;
    int unsigned                target;
    int unsigned                pick;
    int unsigned                len;
    int unsigned                random_start;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = wrs_pkg::REG_MATCH_VALUE;
    cfg_wdata  = '0;
    board      = new();
    burst_left = $urandom_range(1, 8);
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: match zero, base zero, no record limit.
    // Empty range on an idle block, then again with last_word set (ignored).
    send_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
    // Run of two, a miss, then a matching last word that opens and closes a run.
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(32'h0000_0000, 1'b1, 1'b1);
    // Open run closed by a wordless item mid-scan.
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'h8000_0000, 1'b0, 1'b0);
    // Mismatching last word ends the run before the summary.
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'h1234_5678, 1'b1, 1'b1);
    // Single-word scans, one miss and one hit.
    send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_item(32'h0000_0000, 1'b1, 1'b1);
    wait_idle();

    // Address wrap with an unaligned base near the top, and a record limit of one:
    // the second run is counted but not recorded.
    write_config(32'hFFFF_FFFF, 32'hFFFF_FFF5, 32'd1);
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    wait_idle();

    // Random phases; each starts idle with a fresh setting of all registers.
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case (phase % 4)
        0:       mv = '0;
        1:       mv = '1;
        default: mv = $urandom;
      endcase
      case (phase % 5)
        0:       ba = '0;
        1:       ba = '1;
        2:       ba = 32'hFFFF_FFE5;
        default: ba = $urandom;
      endcase
      case (phase % 7)
        0:       mr = '1;
        1:       mr = '0;
        2:       mr = 32'd1;
        3:       mr = 32'd2;
        4:       mr = $urandom_range(3, 6);
        5:       mr = 32'h8000_0000;
        default: mr = $urandom;
      endcase
      write_config(mv, ba, mr);
      target = items_sent + $urandom_range(60, 110);
      while (items_sent < target) begin
        pick = $urandom_range(0, 19);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        if (pick == 0) scan_words(0, 1'b1);
        else if (pick < 5) scan_words(len, 1'b1);
        else scan_words(len, 1'b0);
      end
      wait_idle();
      phase++;
    end

    board.flush_leftovers();
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Receiver: take results and check them. Stall on a pattern that changes now
  // and then (always ready, coin toss, mostly stalled, two on two off). Once, hold
  // off for a long stretch so the queue fills and the input side backs up.
  initial begin
    int unsigned tick;
    int unsigned mode;
    bit          held;
    out_ready     = 1'b0;
    results_taken = 0;
    tick          = 0;
    mode          = 0;
    held          = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      tick++;
      if (out_valid && out_ready) begin
        board.check_result(out_item);
        results_taken++;
      end
      if (!held && results_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (tick % 97 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((tick % 4) < 2);
        endcase
      end
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog: no item moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule
